[hw/rtl/afm_pkg.sv]
`default_nettype none
package afm_pkg;

    localparam int TABLE_ENTRIES = 64;

    localparam int POS_W = 6;
    localparam int CAPTURE_W = 176;

    localparam logic [POS_W-1:0] POS_TYPE_HI = POS_W'(12);
    localparam logic [POS_W-1:0] POS_TYPE_LO = POS_W'(13);
    localparam logic [POS_W-1:0] POS_HW_LEN = POS_W'(18);
    localparam logic [POS_W-1:0] POS_PROTO_LEN = POS_W'(19);
    localparam logic [POS_W-1:0] POS_CAPTURE_START = POS_W'(20);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(41);
    localparam logic [POS_W-1:0] POS_DONE = POS_W'(42);

    localparam logic [7:0] ETHERTYPE_HI = 8'h08;
    localparam logic [7:0] ETHERTYPE_LO = 8'h06;
    localparam logic [7:0] HW_LEN = 8'd6;
    localparam logic [7:0] PROTO_LEN = 8'd4;

    localparam logic [15:0] CHANGES_MAX = 16'hFFFF;

    // lookup item walking down the cell row
    typedef struct packed {
        logic        active;
        logic        done;
        logic        fresh;
        logic [15:0] count;
        logic [31:0] sip;
        logic [47:0] smac;
        logic [31:0] now;
    } token_t;

    typedef struct packed {
        logic at_last;
        logic fire;
    } parse_status_t;

endpackage
`default_nettype wire

[hw/rtl/afm_channels.sv]
`default_nettype none
interface afm_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic [7:0]  ingress_port;
    logic [31:0] now_seconds;

    modport source (output valid, frame_byte, frame_end, ingress_port, now_seconds,
                    input ready);
    modport sink (input valid, frame_byte, frame_end, ingress_port, now_seconds,
                  output ready);
endinterface

interface afm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
    logic [7:0]  event_port;
    logic [15:0] change_count;
    logic        new_address;
    logic        table_full;

    modport source (output valid, opcode, sender_mac, sender_ip, target_mac, target_ip,
                    event_port, change_count, new_address, table_full,
                    input ready);
    modport sink (input valid, opcode, sender_mac, sender_ip, target_mac, target_ip,
                  event_port, change_count, new_address, table_full,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/afm_parser.sv]
`default_nettype none
module afm_parser (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             accept,
    input  wire logic [7:0]                       frame_byte,
    input  wire logic                             frame_end,
    output afm_pkg::parse_status_t                status,
    output logic [afm_pkg::CAPTURE_W-1:0]         captured,
    output logic [afm_pkg::CAPTURE_W-1:0]         capture_next
);

    logic [afm_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic                          qual_reg, qual_next;
    logic [afm_pkg::CAPTURE_W-1:0] cap_reg, cap_next;
    logic                          bad;

    always_comb
    begin
        bad = ((pos_reg == afm_pkg::POS_TYPE_HI) && (frame_byte != afm_pkg::ETHERTYPE_HI)) ||
              ((pos_reg == afm_pkg::POS_TYPE_LO) && (frame_byte != afm_pkg::ETHERTYPE_LO)) ||
              ((pos_reg == afm_pkg::POS_HW_LEN) && (frame_byte != afm_pkg::HW_LEN)) ||
              ((pos_reg == afm_pkg::POS_PROTO_LEN) && (frame_byte != afm_pkg::PROTO_LEN));
        pos_next  = pos_reg;
        qual_next = qual_reg;
        cap_next  = cap_reg;
        if (pos_reg != afm_pkg::POS_DONE)
        begin
            if (bad)
            begin
                qual_next = 1'b0;
            end
            if (pos_reg >= afm_pkg::POS_CAPTURE_START)
            begin
                cap_next = {cap_reg[afm_pkg::CAPTURE_W-9:0], frame_byte};
            end
            pos_next = pos_reg + afm_pkg::POS_W'(1);
        end
        if (frame_end)
        begin
            pos_next  = '0;
            qual_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            qual_reg <= 1'b1;
            cap_reg  <= '0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            qual_reg <= qual_next;
            cap_reg  <= cap_next;
        end
    end

    // checked bytes all lie before byte 41, so the stored flag is final here
    assign status.at_last = (pos_reg == afm_pkg::POS_LAST);
    assign status.fire    = accept && (pos_reg == afm_pkg::POS_LAST) && qual_reg;
    assign captured       = cap_reg;
    assign capture_next   = cap_next;

endmodule
`default_nettype wire

[hw/rtl/afm_cell.sv]
`default_nettype none
module afm_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire afm_pkg::token_t tok_in,
    output afm_pkg::token_t      tok_out
);

    logic        valid_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic [31:0] seen_reg;
    logic [15:0] changes_reg;

    logic            act_reg;
    afm_pkg::token_t tok_reg, tok_next;
    logic            hit, alloc;
    logic [15:0]     cnt_next;

    always_comb
    begin
        hit   = tok_in.active && !tok_in.done && valid_reg && (ip_reg == tok_in.sip);
        // valid entries form a prefix, so the first free cell ends the search
        alloc = tok_in.active && !tok_in.done && !valid_reg;
        cnt_next = changes_reg;
        if ((mac_reg != tok_in.smac) && (changes_reg != afm_pkg::CHANGES_MAX))
        begin
            cnt_next = changes_reg + 16'd1;
        end
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.done  = 1'b1;
            tok_next.fresh = 1'b0;
            tok_next.count = cnt_next;
        end
        else if (alloc)
        begin
            tok_next.done  = 1'b1;
            tok_next.fresh = 1'b1;
            tok_next.count = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            act_reg   <= 1'b0;
        end
        else
        begin
            act_reg <= tok_next.active;
            if (alloc)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (hit || alloc)
        begin
            ip_reg      <= tok_in.sip;
            mac_reg     <= tok_in.smac;
            seen_reg    <= tok_in.now;
            changes_reg <= tok_next.count;
        end
    end

    // of the token, only the active flag is reset; payload bits follow it
    always_comb
    begin
        tok_out        = tok_reg;
        tok_out.active = act_reg;
    end

endmodule
`default_nettype wire

[hw/rtl/arp_frame_monitor.sv]
`default_nettype none
// Channel   Dir  Payload                                             Accepted when
// in_ch     in   frame_byte, frame_end, ingress_port, now_seconds    valid && ready
// out_ch    out  opcode, MACs, IPs, event_port, change_count, flags  valid && ready
//
// One byte per cycle while no table lookup is running.
// The 42nd byte of a qualifying ARP frame launches a lookup that walks the
// row of TABLE_ENTRIES cells, one cell per cycle: in_ch is held off until the
// item leaves the last cell, then the event sits in the output register.
// Bytes keep flowing while an event waits; only the next 42nd byte stalls.
// rst_n clears the table valid bits, the byte position and all handshakes.
module arp_frame_monitor (
    input wire logic clk,
    input wire logic rst_n,
    afm_in_if.sink   in_ch,
    afm_out_if.source out_ch
);

    afm_pkg::parse_status_t            status;
    logic [afm_pkg::CAPTURE_W-1:0]     captured, capture_next;
    logic [afm_pkg::CAPTURE_W-1:0]     event_reg;
    logic                              accept;
    logic                              busy_reg;
    logic                              out_valid_reg;
    logic [7:0]                        port_reg;
    logic [15:0]                       count_reg;
    logic                              fresh_reg, full_reg;
    afm_pkg::token_t                   chain [afm_pkg::TABLE_ENTRIES+1];
    afm_pkg::token_t                   tail;
    logic [afm_pkg::TABLE_ENTRIES-1:0] act_vec;

    // an event needs a free output register, so apart from a lookup only the last header byte waits
    assign in_ch.ready = !busy_reg && !(status.at_last && out_valid_reg);
    assign accept      = in_ch.valid && in_ch.ready;

    afm_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .frame_byte   (in_ch.frame_byte),
        .frame_end    (in_ch.frame_end),
        .status       (status),
        .captured     (captured),
        .capture_next (capture_next)
    );

    // lookup item enters cell 0 in the cycle the 42nd byte is taken
    assign chain[0] = '{active: status.fire,
                        done:   1'b0,
                        fresh:  1'b1,
                        count:  16'd0,
                        sip:    capture_next[111:80],
                        smac:   capture_next[159:112],
                        now:    in_ch.now_seconds};

    for (genvar i = 0; i < afm_pkg::TABLE_ENTRIES; i++)
    begin : g_cell
        afm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
        assign act_vec[i] = chain[i+1].active;
    end

    assign tail = chain[afm_pkg::TABLE_ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (status.fire)
            begin
                busy_reg <= 1'b1;
            end
            else if (tail.active)
            begin
                busy_reg <= 1'b0;
            end
            if (tail.active)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.fire)
        begin
            port_reg <= in_ch.ingress_port;
        end
        if (tail.active)
        begin
            // capture is still frozen by busy; hold it so later bytes can flow
            event_reg <= captured;
            // fell off the end unmatched: table full, nothing stored
            count_reg <= tail.done ? tail.count : 16'd0;
            fresh_reg <= tail.done ? tail.fresh : 1'b1;
            full_reg  <= !tail.done;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.opcode       = event_reg[175:160];
    assign out_ch.sender_mac   = event_reg[159:112];
    assign out_ch.sender_ip    = event_reg[111:80];
    assign out_ch.target_mac   = event_reg[79:32];
    assign out_ch.target_ip    = event_reg[31:0];
    assign out_ch.event_port   = port_reg;
    assign out_ch.change_count = count_reg;
    assign out_ch.new_address  = fresh_reg;
    assign out_ch.table_full   = full_reg;

    a_one_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(act_vec) <= 1)
        else $error("more than one lookup in the cell row");

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !in_ch.ready)
        else $error("input taken during lookup");

    a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.fire |=> busy_reg)
        else $error("lookup launched without busy");

    a_tail_free: assert property (@(posedge clk) disable iff (!rst_n)
        tail.active |-> (busy_reg && !out_valid_reg))
        else $error("lookup result with output register occupied");

endmodule
`default_nettype wire

[bench/arp_frame_monitor_tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module arp_frame_monitor_tb;

    localparam int HALF_PERIOD = 6;
    localparam int STALL_LIMIT = 3000;   // cycles with no handshake on either side
    localparam int HOLD_OFF = 400;       // long receiver hold-off
    localparam int QUIET_TAIL = 400;     // no idling once this few items remain
    localparam int FILL_FRAMES = 12;     // distinct senders in a row
    localparam int RANDOM_FRAMES = 10;
    localparam int POOL_SIZE = 72;

    // one input item
    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic [7:0]  port;
        logic [31:0] stamp;
    } byte_item_t;

    // one ARP event
    typedef struct {
        logic [15:0] opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [47:0] target_mac;
        logic [31:0] target_ip;
        logic [7:0]  event_port;
        logic [15:0] change_count;
        logic        new_address;
        logic        table_full;
    } arp_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    afm_in_if  in_ch ();
    afm_out_if out_ch ();

    arp_frame_monitor i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #(HALF_PERIOD) clk = ~clk;

    byte_item_t pending_bytes[$];
    arp_event_t expected_events[$];
    int         error_count = 0;
    int         events_seen = 0;
    bit         quiet = 1'b0;

    // shadow of the parser and the sender table
    int          shadow_pos = 0;
    bit          shadow_ok = 1'b1;
    logic [7:0]  shadow_capture[22];
    bit          tbl_valid[afm_pkg::TABLE_ENTRIES];
    logic [31:0] tbl_ip[afm_pkg::TABLE_ENTRIES];
    logic [47:0] tbl_mac[afm_pkg::TABLE_ENTRIES];
    logic [15:0] tbl_changes[afm_pkg::TABLE_ENTRIES];

    logic [31:0] ip_pool[POOL_SIZE];
    logic [47:0] mac_pool[POOL_SIZE][2];

    function automatic logic [63:0] capture_field(int first, int count);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < count; i++)
            v = {v[55:0], shadow_capture[first + i]};
        return v;
    endfunction

    // advance the shadow parser by one accepted byte
    task automatic parse_byte(input byte_item_t it);
        arp_event_t ev;
        int hit, free_slot;
        if (shadow_pos <= int'(afm_pkg::POS_LAST)) begin
            if ((shadow_pos == int'(afm_pkg::POS_TYPE_HI) && it.data != afm_pkg::ETHERTYPE_HI) ||
                (shadow_pos == int'(afm_pkg::POS_TYPE_LO) && it.data != afm_pkg::ETHERTYPE_LO) ||
                (shadow_pos == int'(afm_pkg::POS_HW_LEN) && it.data != afm_pkg::HW_LEN) ||
                (shadow_pos == int'(afm_pkg::POS_PROTO_LEN) && it.data != afm_pkg::PROTO_LEN))
                shadow_ok = 1'b0;
            if (shadow_pos >= int'(afm_pkg::POS_CAPTURE_START))
                shadow_capture[shadow_pos - int'(afm_pkg::POS_CAPTURE_START)] = it.data;
            if (shadow_pos == int'(afm_pkg::POS_LAST) && shadow_ok) begin
                ev.opcode       = 16'(capture_field(0, 2));
                ev.sender_mac   = 48'(capture_field(2, 6));
                ev.sender_ip    = 32'(capture_field(8, 4));
                ev.target_mac   = 48'(capture_field(12, 6));
                ev.target_ip    = 32'(capture_field(18, 4));
                ev.event_port   = it.port;
                ev.change_count = '0;
                ev.new_address  = 1'b1;
                ev.table_full   = 1'b0;
                hit = -1;
                free_slot = -1;
                for (int i = 0; i < afm_pkg::TABLE_ENTRIES; i++) begin
                    if (tbl_valid[i]) begin
                        if (hit < 0 && tbl_ip[i] == ev.sender_ip)
                            hit = i;
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (hit >= 0) begin
                    ev.new_address = 1'b0;
                    if (tbl_mac[hit] != ev.sender_mac &&
                        tbl_changes[hit] != afm_pkg::CHANGES_MAX)
                        tbl_changes[hit] = tbl_changes[hit] + 16'd1;
                    ev.change_count = tbl_changes[hit];
                    tbl_mac[hit] = ev.sender_mac;
                end else if (free_slot >= 0) begin
                    tbl_valid[free_slot] = 1'b1;
                    tbl_ip[free_slot] = ev.sender_ip;
                    tbl_mac[free_slot] = ev.sender_mac;
                    tbl_changes[free_slot] = '0;
                end else begin
                    ev.table_full = 1'b1;
                end
                expected_events.push_back(ev);
            end
            shadow_pos++;
        end
        if (it.last) begin
            shadow_pos = 0;
            shadow_ok = 1'b1;
        end
    endtask

    // queue one frame; bad_at >= 0 corrupts the byte at that offset
    task automatic queue_frame(input logic [15:0] opcode, input logic [47:0] smac,
                               input logic [31:0] sip, input logic [47:0] tmac,
                               input logic [31:0] tip, input int len, input int bad_at);
        logic [7:0] fr[];
        byte_item_t it;
        fr = new[len > 64 ? len : 64];
        foreach (fr[i])
            fr[i] = 8'($urandom);
        fr[12] = afm_pkg::ETHERTYPE_HI;
        fr[13] = afm_pkg::ETHERTYPE_LO;
        fr[18] = afm_pkg::HW_LEN;
        fr[19] = afm_pkg::PROTO_LEN;
        {fr[20], fr[21]} = opcode;
        {fr[22], fr[23], fr[24], fr[25], fr[26], fr[27]} = smac;
        {fr[28], fr[29], fr[30], fr[31]} = sip;
        {fr[32], fr[33], fr[34], fr[35], fr[36], fr[37]} = tmac;
        {fr[38], fr[39], fr[40], fr[41]} = tip;
        if (bad_at >= 0)
            fr[bad_at] = fr[bad_at] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < len; i++) begin
            it.data = fr[i];
            it.last = (i == len - 1);
            it.port = 8'($urandom);
            it.stamp = $urandom;
            pending_bytes.push_back(it);
        end
    endtask

    // random frame content around a chosen sender
    task automatic queue_sender(input logic [31:0] sip, input logic [47:0] smac,
                                input int len, input int bad_at);
        queue_frame(16'($urandom), smac, sip, {16'($urandom), $urandom}, $urandom,
                    len, bad_at);
    endtask

    // Sender: one item per slot, random idle bursts until the tail of the run.
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        byte_item_t it;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            quiet <= pending_bytes.size() < QUIET_TAIL;
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                it = pending_bytes.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.frame_byte <= it.data;
                in_ch.frame_end <= it.last;
                in_ch.ingress_port <= it.port;
                in_ch.now_seconds <= it.stamp;
                if (!quiet && $urandom_range(0, 11) == 0)
                    send_gap <= $urandom_range(1, 7);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off after a few events
    // so the lookup fills the output register and backs up the byte stream.
    int stall_left = 0;
    bit held_once = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (!held_once && events_seen == 5)
        begin
            held_once <= 1'b1;
            stall_left <= HOLD_OFF;
            out_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 6);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        error_count++;
    endtask

    // Monitors: input acceptances feed the shadow, output acceptances are checked.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        arp_event_t ev;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                parse_byte('{in_ch.frame_byte, in_ch.frame_end, in_ch.ingress_port,
                             in_ch.now_seconds});
            if (out_ch.valid && out_ch.ready)
            begin
                events_seen <= events_seen + 1;
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected event, expected none, actual ip %0h",
                             $time, out_ch.sender_ip);
                    error_count++;
                end
                else
                begin
                    ev = expected_events.pop_front();
                    if (out_ch.opcode !== ev.opcode)
                        report("opcode", 64'(ev.opcode), 64'(out_ch.opcode));
                    if (out_ch.sender_mac !== ev.sender_mac)
                        report("sender_mac", 64'(ev.sender_mac), 64'(out_ch.sender_mac));
                    if (out_ch.sender_ip !== ev.sender_ip)
                        report("sender_ip", 64'(ev.sender_ip), 64'(out_ch.sender_ip));
                    if (out_ch.target_mac !== ev.target_mac)
                        report("target_mac", 64'(ev.target_mac), 64'(out_ch.target_mac));
                    if (out_ch.target_ip !== ev.target_ip)
                        report("target_ip", 64'(ev.target_ip), 64'(out_ch.target_ip));
                    if (out_ch.event_port !== ev.event_port)
                        report("event_port", 64'(ev.event_port), 64'(out_ch.event_port));
                    if (out_ch.change_count !== ev.change_count)
                        report("change_count", 64'(ev.change_count),
                               64'(out_ch.change_count));
                    if (out_ch.new_address !== ev.new_address)
                        report("new_address", 64'(ev.new_address), 64'(out_ch.new_address));
                    if (out_ch.table_full !== ev.table_full)
                        report("table_full", 64'(ev.table_full), 64'(out_ch.table_full));
                end
            end
            // watchdog: any handshake restarts the count
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [47:0] m;
        int k;
        in_ch.valid = 1'b0;
        in_ch.frame_byte = '0;
        in_ch.frame_end = 1'b0;
        in_ch.ingress_port = '0;
        in_ch.now_seconds = '0;
        out_ch.ready = 1'b0;
        foreach (tbl_valid[i])
            tbl_valid[i] = 1'b0;
        foreach (ip_pool[i])
        begin
            ip_pool[i] = $urandom;
            mac_pool[i][0] = {16'($urandom), $urandom};
            mac_pool[i][1] = {16'($urandom), $urandom};
        end
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        mac_pool[0][0] = '0;
        mac_pool[1][0] = '1;

        // directed: field extremes
        queue_frame('0, '0, '0, '0, '0, 42, -1);
        queue_frame('1, '1, '1, '1, '1, 42, -1);
        // known sender, same MAC then a changed MAC
        queue_sender(ip_pool[0], mac_pool[0][0], 50, -1);
        queue_sender(ip_pool[0], mac_pool[0][1], 42, -1);
        queue_sender(ip_pool[1], mac_pool[1][1], 43, -1);
        // short frames: one byte, ends one byte early
        queue_sender(ip_pool[2], mac_pool[2][0], 1, -1);
        queue_sender(ip_pool[2], mac_pool[2][0], 41, -1);
        // checked bytes that do not match
        queue_sender(ip_pool[3], mac_pool[3][0], 42, int'(afm_pkg::POS_TYPE_HI));
        queue_sender(ip_pool[3], mac_pool[3][0], 42, int'(afm_pkg::POS_TYPE_LO));
        queue_sender(ip_pool[3], mac_pool[3][0], 60, int'(afm_pkg::POS_HW_LEN));
        queue_sender(ip_pool[3], mac_pool[3][0], 42, int'(afm_pkg::POS_PROTO_LEN));
        // long frame, then a clean frame right after
        queue_sender(ip_pool[4], mac_pool[4][0], 63, -1);
        queue_sender(ip_pool[5], mac_pool[5][0], 42, -1);

        // a run of distinct senders
        for (int i = 0; i < FILL_FRAMES; i++)
            queue_sender(ip_pool[i], mac_pool[i][$urandom_range(0, 1)],
                         $urandom_range(42, 48), -1);

        // random frames: mostly well formed, some short or corrupted
        for (int i = 0; i < RANDOM_FRAMES; i++)
        begin
            k = $urandom_range(0, POOL_SIZE - 1);
            m = mac_pool[k][$urandom_range(0, 1)];
            case ($urandom_range(0, 9))
                0: queue_sender(ip_pool[k], m, $urandom_range(1, 41), -1);
                1: queue_sender(ip_pool[k], m, 42,
                                $urandom_range(0, 1)
                                    ? int'(afm_pkg::POS_TYPE_HI) + $urandom_range(0, 1)
                                    : int'(afm_pkg::POS_HW_LEN) + $urandom_range(0, 1));
                default: queue_sender(ip_pool[k], m, $urandom_range(42, 64), -1);
            endcase
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_bytes.size() == 0 && !in_ch.valid && expected_events.size() == 0);
        repeat (3 * afm_pkg::TABLE_ENTRIES) @(posedge clk);
        if (error_count == 0 && expected_events.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
hw/rtl/afm_pkg.sv
hw/rtl/afm_channels.sv
hw/rtl/afm_parser.sv
hw/rtl/afm_cell.sv
hw/rtl/arp_frame_monitor.sv
bench/arp_frame_monitor_tb.sv
